// File: design/bpa_pkg.sv
package bpa_pkg;

    localparam int PAGES_DEF     = 1024;
    localparam int TOP_ORDER_DEF = 10;
    localparam int ORDER_W       = 4;
    localparam int PAGE_W        = 10;
    localparam int STATUS_W      = 2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_BAD    = 2'd2
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [ORDER_W-1:0] order;
        logic [PAGE_W-1:0]  page_index;
    } bpa_in_t;

    typedef struct packed {
        logic [PAGE_W-1:0] block_index;
        status_t           status;
    } bpa_out_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_UNLINK,
        S_UNL_N,
        S_UNL_Q,
        S_UNL_DONE,
        S_SPLIT,
        S_PUSH,
        S_PUSH_H,
        S_PUSH_DONE,
        S_ALLOC_FIN,
        S_BUDDY,
        S_BUDDY_MID,
        S_BUDDY_CHK,
        S_MERGE,
        S_OUT
    } bpa_state_t;

endpackage

// File: design/bpa_mem.sv
module bpa_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/buddy_page_allocator.sv
// Buddy page allocator over PAGES pages with per-order doubly linked free
// lists held in block RAM. After reset one sweep clears the flags, nulls the
// links and carves the initial layout, one page per cycle; s_ready is low
// meanwhile. A small sequencer then runs one transaction at a time around
// one shared address adder and the link and flag RAMs (one read port,
// registered). An allocate searches upward past empty orders, unlinks a
// block and splits it down to the requested order; a failed one stops at
// the top order. A free merges with its free buddy order by order until
// the buddy is not free or merging reaches the top order. One result per
// request; the next request is taken only once the previous result is
// accepted, possibly in that cycle.
module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int PAGES     = PAGES_DEF,
    parameter int TOP_ORDER = TOP_ORDER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bpa_pkg::bpa_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bpa_pkg::bpa_out_t m_data
);
    localparam int AW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int LW   = $clog2(PAGES + 1);
    localparam int NORD = TOP_ORDER + 1;
    localparam int XW   = ((LW + 1) > (TOP_ORDER + 2)) ? LW + 1 : TOP_ORDER + 2;
    localparam logic [LW-1:0] NIL = LW'(PAGES);

    bpa_state_t state_reg, state_next, ret_reg, ret_next;

    logic [LW-1:0] head_reg [NORD];
    logic [LW-1:0] cnt_reg  [NORD];

    logic [XW-1:0]      idx_reg, idx_next;
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [ORDER_W-1:0] ord_reg, ord_next;
    logic               cmd_reg, cmd_next;
    logic [LW-1:0]      p_reg, p_next;
    logic [LW-1:0]      b_reg, b_next;
    logic [LW-1:0]      n_reg, n_next;
    logic [LW-1:0]      q_reg, q_next;
    logic [ORDER_W-1:0] uk_reg, uk_next;
    logic [LW-1:0]      up_reg, up_next;
    logic               mout_valid_reg, mout_valid_next;
    bpa_out_t           mout_reg, mout_next;
    logic               lhw;
    logic [ORDER_W-1:0] lhk;
    logic [LW-1:0]      lhv;
    logic               cinc, cdec;

    // memories: next, prev, flags {head, used} (flag write enables per bit)
    logic          nx_we, pv_we;
    logic [1:0]    fl_we;
    logic [AW-1:0] nx_wa, pv_wa, fl_wa, nx_ra, pv_ra, fl_ra;
    logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [1:0]    fl_wd, fl_rd;

    bpa_mem #(.DEPTH(PAGES), .WIDTH(LW), .AW(AW)) u_next (
        .aclk(aclk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .raddr(nx_ra), .rdata(nx_rd));
    bpa_mem #(.DEPTH(PAGES), .WIDTH(LW), .AW(AW)) u_prev (
        .aclk(aclk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .raddr(pv_ra), .rdata(pv_rd));
    bpa_mem #(.DEPTH(PAGES), .WIDTH(1), .AW(AW)) u_head (
        .aclk(aclk), .we(fl_we[1]), .waddr(fl_wa), .wdata(fl_wd[1]),
        .raddr(fl_ra), .rdata(fl_rd[1]));
    bpa_mem #(.DEPTH(PAGES), .WIDTH(1), .AW(AW)) u_used (
        .aclk(aclk), .we(fl_we[0]), .waddr(fl_wa), .wdata(fl_wd[0]),
        .raddr(fl_ra), .rdata(fl_rd[0]));

    // shared adder: base + (1 << shift) or base - (1 << shift)
    logic [XW-1:0]      add_a, add_r;
    logic [ORDER_W-1:0] add_s;
    logic               add_sub;
    logic [XW-1:0]      add_pw;
    always_comb begin
        add_pw = XW'(1) << add_s;
        add_r  = add_sub ? (add_a - add_pw) : (add_a + add_pw);
    end

    function automatic logic is_pg(logic [LW-1:0] v);
        return XW'(v) < XW'(PAGES);
    endfunction

    logic [XW-1:0] sz, sz2;
    logic [XW-1:0] rem_x;
    logic [ORDER_W-1:0] carve_k;
    always_comb begin
        sz    = XW'(1) << k_reg;
        sz2   = XW'(1) << (k_reg + ORDER_W'(1));
        rem_x = XW'(PAGES) - idx_reg;
        carve_k = '0;
        for (int i = 0; i < NORD; i++) begin
            if ((XW'(1) << i) <= rem_x) begin
                carve_k = ORDER_W'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        ord_next = ord_reg;
        cmd_next = cmd_reg;
        p_next = p_reg;
        b_next = b_reg;
        n_next = n_reg;
        q_next = q_reg;
        uk_next = uk_reg;
        up_next = up_reg;
        mout_valid_next = mout_valid_reg;
        mout_next = mout_reg;
        if (mout_valid_reg && m_ready) begin
            mout_valid_next = 1'b0;
        end
        nx_we = 1'b0;  nx_wa = '0; nx_wd = NIL; nx_ra = '0;
        pv_we = 1'b0;  pv_wa = '0; pv_wd = NIL; pv_ra = '0;
        fl_we = 2'b00; fl_wa = '0; fl_wd = '0;  fl_ra = '0;
        lhw = 1'b0; lhk = '0; lhv = NIL; cinc = 1'b0; cdec = 1'b0;
        add_a = '0; add_s = '0; add_sub = 1'b0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                // sweep: clear flags, null links; at carve boundaries push block
                fl_we = 2'b11; fl_wa = AW'(idx_reg);
                nx_we = 1'b1; nx_wa = AW'(idx_reg);
                pv_we = 1'b1; pv_wa = AW'(idx_reg);
                if (idx_reg == XW'(b_reg)) begin
                    fl_wd = 2'b10;
                    nx_wd = head_reg[carve_k];
                    lhw = 1'b1; lhk = carve_k; lhv = LW'(idx_reg); cinc = 1'b1;
                    add_a = idx_reg; add_s = carve_k;
                    b_next = LW'(add_r);
                    // a following top-order block becomes this block's prev
                    if (XW'(carve_k) == XW'(TOP_ORDER) &&
                        rem_x >= (XW'(2) << TOP_ORDER)) begin
                        pv_wd = LW'(add_r);
                    end
                end
                idx_next = idx_reg + XW'(1);
                if (idx_reg == XW'(PAGES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = !mout_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    cmd_next = s_data.cmd;
                    ord_next = s_data.order;
                    k_next = s_data.order;
                    p_next = LW'(s_data.page_index);
                    b_next = LW'(s_data.page_index);
                    fl_ra = AW'(s_data.page_index);
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (XW'(ord_reg) > XW'(TOP_ORDER)) begin
                    mout_next = '{block_index: '0, status: ST_BAD};
                    state_next = S_OUT;
                end else if (cmd_reg == CMD_ALLOC) begin
                    state_next = S_SEARCH;
                end else if (!is_pg(p_reg) || !fl_rd[0] ||
                             (XW'(p_reg) & (sz - XW'(1))) != '0 ||
                             XW'(p_reg) + sz > XW'(PAGES)) begin
                    mout_next = '{block_index: '0, status: ST_BAD};
                    state_next = S_OUT;
                end else begin
                    fl_we = 2'b01; fl_wa = AW'(p_reg); fl_wd = 2'b00;
                    state_next = S_BUDDY;
                end
            end
            S_SEARCH: begin
                if (is_pg(head_reg[k_reg])) begin
                    p_next = head_reg[k_reg];
                    uk_next = k_reg; up_next = head_reg[k_reg];
                    nx_ra = AW'(head_reg[k_reg]); pv_ra = AW'(head_reg[k_reg]);
                    ret_next = S_SPLIT;
                    state_next = S_UNLINK;
                end else if (XW'(k_reg) >= XW'(TOP_ORDER)) begin
                    mout_next = '{block_index: '0, status: ST_NOFREE};
                    state_next = S_OUT;
                end else begin
                    k_next = k_reg + ORDER_W'(1);
                end
            end
            S_UNLINK: begin
                n_next = nx_rd; q_next = pv_rd;
                if (is_pg(pv_rd)) begin
                    nx_we = 1'b1; nx_wa = AW'(pv_rd); nx_wd = nx_rd;
                end else begin
                    lhw = 1'b1; lhk = uk_reg; lhv = nx_rd;
                end
                state_next = S_UNL_N;
            end
            S_UNL_N: begin
                if (is_pg(n_reg)) begin
                    pv_we = 1'b1; pv_wa = AW'(n_reg); pv_wd = q_reg;
                end
                nx_we = 1'b1; nx_wa = AW'(up_reg); nx_wd = NIL;
                state_next = S_UNL_Q;
            end
            S_UNL_Q: begin
                pv_we = 1'b1; pv_wa = AW'(up_reg); pv_wd = NIL;
                cdec = 1'b1; lhk = uk_reg;
                state_next = S_UNL_DONE;
            end
            S_UNL_DONE: begin
                state_next = ret_reg;
            end
            S_SPLIT: begin
                if (k_reg > ord_reg) begin
                    add_a = XW'(p_reg); add_s = k_reg - ORDER_W'(1);
                    k_next = k_reg - ORDER_W'(1);
                    if (add_r < XW'(PAGES)) begin
                        uk_next = k_reg - ORDER_W'(1); up_next = LW'(add_r);
                        fl_we = 2'b10; fl_wa = AW'(add_r); fl_wd = 2'b10;
                        ret_next = S_SPLIT;
                        state_next = S_PUSH;
                    end
                end else begin
                    fl_we = 2'b01; fl_wa = AW'(p_reg); fl_wd = 2'b01;
                    state_next = S_ALLOC_FIN;
                end
            end
            S_ALLOC_FIN: begin
                mout_next = '{block_index: PAGE_W'(p_reg), status: ST_OK};
                state_next = S_OUT;
            end
            S_PUSH: begin
                nx_we = 1'b1; nx_wa = AW'(up_reg); nx_wd = head_reg[uk_reg];
                pv_we = 1'b1; pv_wa = AW'(up_reg); pv_wd = NIL;
                state_next = S_PUSH_H;
            end
            S_PUSH_H: begin
                if (is_pg(head_reg[uk_reg])) begin
                    pv_we = 1'b1; pv_wa = AW'(head_reg[uk_reg]); pv_wd = up_reg;
                end
                lhw = 1'b1; lhk = uk_reg; lhv = up_reg; cinc = 1'b1;
                state_next = S_PUSH_DONE;
            end
            S_PUSH_DONE: begin
                state_next = ret_reg;
            end
            S_BUDDY: begin
                // compute buddy address into n_reg, read its flags
                if (XW'(k_reg) == XW'(TOP_ORDER)) begin
                    uk_next = k_reg; up_next = b_reg; ret_next = S_OUT;
                    mout_next = '{block_index: '0, status: ST_OK};
                    state_next = S_PUSH;
                end else begin
                    add_s = k_reg;
                    add_a = XW'(b_reg);
                    if ((XW'(b_reg) & (sz2 - XW'(1))) == '0) begin
                        add_sub = 1'b0;
                        n_next = (add_r + sz > XW'(PAGES)) ? NIL : LW'(add_r);
                    end else begin
                        add_sub = 1'b1;
                        n_next = (XW'(b_reg) < sz) ? NIL : LW'(add_r);
                    end
                    fl_ra = AW'(LW'(add_r));
                    state_next = S_BUDDY_MID;
                end
            end
            S_BUDDY_MID: begin
                q_next = {LW{1'b0}};
                q_next[0] = fl_rd[1] && !fl_rd[0];
                add_a = XW'(n_reg); add_s = k_reg - ORDER_W'(1);
                fl_ra = AW'(LW'(add_r));
                state_next = S_BUDDY_CHK;
            end
            S_BUDDY_CHK: begin
                add_a = XW'(n_reg); add_s = k_reg - ORDER_W'(1);
                if (!is_pg(n_reg) || !q_reg[0] ||
                    (k_reg != '0 && add_r < XW'(PAGES) && fl_rd[1])) begin
                    uk_next = k_reg; up_next = b_reg; ret_next = S_OUT;
                    mout_next = '{block_index: '0, status: ST_OK};
                    state_next = S_PUSH;
                end else begin
                    uk_next = k_reg; up_next = n_reg;
                    nx_ra = AW'(n_reg); pv_ra = AW'(n_reg);
                    ret_next = S_MERGE;
                    state_next = S_UNLINK;
                end
            end
            S_MERGE: begin
                // up_reg holds the buddy; n_reg was reused by the unlink
                fl_we = 2'b10; fl_wd = 2'b00;
                if (up_reg < b_reg) begin
                    fl_wa = AW'(b_reg);
                    b_next = up_reg;
                end else begin
                    fl_wa = AW'(up_reg);
                end
                k_next = k_reg + ORDER_W'(1);
                state_next = S_BUDDY;
            end
            S_OUT: begin
                if (!mout_valid_reg) begin
                    mout_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            ret_reg <= S_IDLE;
            idx_reg <= '0;
            b_reg <= '0;
            mout_valid_reg <= 1'b0;
            for (int i = 0; i < NORD; i++) begin
                head_reg[i] <= NIL;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            idx_reg <= idx_next;
            b_reg <= b_next;
            mout_valid_reg <= mout_valid_next;
            if (lhw) begin
                head_reg[lhk] <= lhv;
            end
            if (cinc) begin
                cnt_reg[lhk] <= cnt_reg[lhk] + LW'(1);
            end else if (cdec) begin
                cnt_reg[lhk] <= cnt_reg[lhk] - LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        ord_reg <= ord_next;
        cmd_reg <= cmd_next;
        p_reg <= p_next;
        n_reg <= n_next;
        q_reg <= q_next;
        uk_reg <= uk_next;
        up_reg <= up_next;
        mout_reg <= mout_next;
    end

    assign m_valid = mout_valid_reg;
    assign m_data  = mout_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !mout_valid_reg) |=> m_valid)
        else $error("result lost");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed while waiting");
endmodule
